// ----- rtl/sobel_pkg.sv -----
package sobel_pkg;

    // Field and register widths
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 12;
    localparam int THR_W   = 8;
    localparam int ROW_W   = 12;
    localparam int GRAD_W  = 11;
    localparam int SQ_W    = 20;
    localparam int SUM_W   = 21;
    localparam int MAG_W   = 8;
    localparam int WIN_N   = 9;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINE_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_EDGE_THRESHOLD = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] RST_LINE_WIDTH     = 12'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = 12'd480;
    localparam logic [THR_W-1:0] RST_EDGE_THRESHOLD = 8'd100;

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    typedef struct packed {
        logic [CFG_W-1:0] line_width;
        logic [CFG_W-1:0] frame_height;
        logic [THR_W-1:0] edge_threshold;
    } t_cfg;

    // One window beat: w[0..8] row-major, top line first
    typedef struct packed {
        logic [WIN_N-1:0][PIX_W-1:0] win;
        logic                        last;
    } t_win_beat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ----- rtl/sobel_queue.sv -----
module sobel_queue
    import sobel_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_win_beat     i_push_data,
    input  logic          i_pop,
    output t_win_beat     o_pop_data,
    output t_queue_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_win_beat        r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_pop_data     = r_slot[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Hold the beat payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- rtl/sobel_front.sv -----
module sobel_front
    import sobel_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [PIX_W-1:0] i_pixel,
    input  t_queue_status    i_q_status,
    output logic             o_push,
    output t_win_beat        o_push_data
);

    localparam int CW = $clog2(MAX_LINE_WIDTH);
    localparam int LW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int HW = ROW_W + 1;

    typedef enum logic {
        F_IDLE,
        F_WRITE
    } t_front_state;

    t_front_state            r_state;
    logic [CW-1:0]           r_col;
    logic [ROW_W-1:0]        r_row;
    logic [PIX_W-1:0]        r_pix;
    logic [WIN_N-1:0][PIX_W-1:0] r_win;
    logic [PIX_W-1:0]        r_rd_a;
    logic [PIX_W-1:0]        r_rd_b;
    logic [PIX_W-1:0]        r_line_a [MAX_LINE_WIDTH];
    logic [PIX_W-1:0]        r_line_b [MAX_LINE_WIDTH];

    logic                    accept;
    logic [LW-1:0]           w_raw;
    logic [LW-1:0]           w_sat;
    logic [HW-1:0]           h_sat;
    logic [LW-1:0]           col_next;
    logic [HW-1:0]           row_next;
    logic                    line_end;
    logic                    plane_end;
    logic                    interior;
    logic [WIN_N-1:0][PIX_W-1:0] n_win;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != F_IDLE) || i_q_status.full;

    // Saturate bounds in use
    always_comb begin
        w_raw = LW'(i_cfg.line_width);
        if (w_raw < LW'(3)) begin
            w_sat = LW'(3);
        end else if (w_raw > LW'(MAX_LINE_WIDTH)) begin
            w_sat = LW'(MAX_LINE_WIDTH);
        end else begin
            w_sat = w_raw;
        end
        h_sat = (i_cfg.frame_height < CFG_W'(3)) ? HW'(3) : HW'(i_cfg.frame_height);
    end

    assign col_next  = LW'(r_col) + LW'(1);
    assign row_next  = HW'(r_row) + HW'(1);
    assign line_end  = (col_next >= w_sat);
    assign plane_end = (row_next >= h_sat);
    assign interior  = (r_col >= CW'(2)) && (r_row >= ROW_W'(2));

    // Shift window left and bring in the new column
    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = r_rd_b;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = r_rd_a;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_pix;
    end

    assign o_push           = (r_state == F_WRITE) && interior;
    assign o_push_data.win  = n_win;
    assign o_push_data.last = (LW'(r_col) == w_sat - LW'(1))
                              && (HW'(r_row) == h_sat - HW'(1));

    // Sequence one pixel: read line stores, then write back and advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_win   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_WRITE;
                    end
                end
                F_WRITE: begin
                    r_state <= F_IDLE;
                    r_win   <= n_win;
                    if (line_end) begin
                        r_col <= '0;
                        r_row <= plane_end ? '0 : row_next[ROW_W-1:0];
                    end else begin
                        r_col <= col_next[CW-1:0];
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // Hold the accepted pixel
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= i_pixel;
        end
    end

    // Line stores: registered read on accept, write back in the next cycle (F_WRITE)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_a <= r_line_a[r_col];
            r_rd_b <= r_line_b[r_col];
        end
        if (r_state == F_WRITE) begin
            r_line_a[r_col] <= r_pix;
            r_line_b[r_col] <= r_rd_a;
        end
    end

endmodule

// ----- rtl/sobel_back.sv -----
module sobel_back
    import sobel_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_queue_status    i_q_status,
    input  t_win_beat        i_pop_data,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [PIX_W-1:0] o_edge_pixel,
    output logic [MAG_W-1:0] o_magnitude,
    output logic             o_frame_last
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQR,
        B_SUM,
        B_ROOT,
        B_OUT
    } t_back_state;

    t_back_state              r_state;
    logic signed [GRAD_W-1:0] r_gh;
    logic signed [GRAD_W-1:0] r_gv;
    logic [SQ_W-1:0]          r_sq_h;
    logic [SQ_W-1:0]          r_sq_v;
    logic [SUM_W-1:0]         r_rem;
    logic [SUM_W-1:0]         r_root;
    logic [SUM_W-1:0]         r_bit;
    logic                     r_last;

    logic [GRAD_W-1:0]        gh_pos, gh_neg, gv_pos, gv_neg;
    logic signed [GRAD_W-1:0] gh;
    logic signed [GRAD_W-1:0] gv;
    logic signed [2*GRAD_W-1:0] sq_h_full;
    logic signed [2*GRAD_W-1:0] sq_v_full;
    logic [SUM_W:0]           trial;
    logic [SUM_W-1:0]         n_rem;
    logic [SUM_W-1:0]         n_root;
    logic [MAG_W-1:0]         mag;

    assign o_pop = (r_state == B_IDLE) && !i_q_status.empty;

    // Form the Sobel sums from the window
    always_comb begin
        gh_pos = GRAD_W'(i_pop_data.win[0]) + (GRAD_W'(i_pop_data.win[1]) << 1)
                 + GRAD_W'(i_pop_data.win[2]);
        gh_neg = GRAD_W'(i_pop_data.win[6]) + (GRAD_W'(i_pop_data.win[7]) << 1)
                 + GRAD_W'(i_pop_data.win[8]);
        gv_pos = GRAD_W'(i_pop_data.win[0]) + (GRAD_W'(i_pop_data.win[3]) << 1)
                 + GRAD_W'(i_pop_data.win[6]);
        gv_neg = GRAD_W'(i_pop_data.win[2]) + (GRAD_W'(i_pop_data.win[5]) << 1)
                 + GRAD_W'(i_pop_data.win[8]);
        gh     = $signed(gh_pos) - $signed(gh_neg);
        gv     = $signed(gv_pos) - $signed(gv_neg);
    end

    assign sq_h_full = r_gh * r_gh;
    assign sq_v_full = r_gv * r_gv;

    // One step of the digit-by-digit square root
    always_comb begin
        trial = {1'b0, r_root} + {1'b0, r_bit};
        if ({1'b0, r_rem} >= trial) begin
            n_rem  = r_rem - trial[SUM_W-1:0];
            n_root = (r_root >> 1) + r_bit;
        end else begin
            n_rem  = r_rem;
            n_root = r_root >> 1;
        end
        mag = n_root[MAG_W+2:3];
    end

    // Sequence gradient, squares, root and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_gh    <= gh;
                        r_gv    <= gv;
                        r_last  <= i_pop_data.last;
                        r_state <= B_SQR;
                    end
                end
                B_SQR: begin
                    r_sq_h  <= SQ_W'(sq_h_full);
                    r_sq_v  <= SQ_W'(sq_v_full);
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_rem   <= SUM_W'(r_sq_h) + SUM_W'(r_sq_v);
                    r_root  <= '0;
                    r_bit   <= SUM_W'(1) << (SUM_W - 1);
                    r_state <= B_ROOT;
                end
                B_ROOT: begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_bit  <= r_bit >> 2;
                    if (r_bit[0]) begin
                        o_magnitude  <= mag;
                        o_edge_pixel <= (mag >= i_cfg.edge_threshold) ? EDGE_ON : EDGE_OFF;
                        o_frame_last <= r_last;
                        o_out_valid  <= 1'b1;
                        r_state      <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/sobel_edge_threshold.sv -----
// Channel  | valid        | stall        | payload
// ---------+--------------+--------------+-----------------------------------------
// input    | i_in_valid   | o_in_stall   | i_pixel
// output   | o_out_valid  | i_out_stall  | o_edge_pixel, o_magnitude, o_frame_last
// config   | i_cfg_we     | (none)       | i_cfg_index, i_cfg_data
//
// The front takes one pixel at a time: a registered line-store read, then write-back.
// The back handles one interior result at a time: gradient, squares, sum, 11 root steps, beat.
// Interior pixels are therefore bound by the back; border pixels need only the front.
// Reset restores the config defaults and clears counters, window and queue; the line
// stores are not cleared. A stalled result holds in the output register while the
// queue keeps absorbing windows; the input stalls once the queue is full.
module sobel_edge_threshold
    import sobel_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [PIX_W-1:0] o_edge_pixel,
    output logic [MAG_W-1:0] o_magnitude,
    output logic             o_frame_last
);

    t_cfg          r_cfg;
    t_queue_status q_status;
    t_win_beat     push_data;
    t_win_beat     pop_data;
    logic          push;
    logic          pop;

    // Take config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width     <= RST_LINE_WIDTH;
            r_cfg.frame_height   <= RST_FRAME_HEIGHT;
            r_cfg.edge_threshold <= RST_EDGE_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINE_WIDTH:     r_cfg.line_width     <= i_cfg_data;
                CFG_FRAME_HEIGHT:   r_cfg.frame_height   <= i_cfg_data;
                CFG_EDGE_THRESHOLD: r_cfg.edge_threshold <= i_cfg_data[THR_W-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    sobel_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel     (i_pixel),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    sobel_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    sobel_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_status   (q_status),
        .i_pop_data   (pop_data),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_edge_pixel (o_edge_pixel),
        .o_magnitude  (o_magnitude),
        .o_frame_last (o_frame_last)
    );

endmodule

// ----- bench/sobel_edge_checker.sv -----
`timescale 1ns / 100ps

module sobel_edge_checker
    import sobel_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [PIX_W-1:0] i_edge_pixel,
    input  logic [MAG_W-1:0] i_magnitude,
    input  logic             i_frame_last,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [PIX_W-1:0] edge_pixel;
        logic [MAG_W-1:0] magnitude;
        logic             frame_last;
    } t_edge_result;

    t_cfg             regs;
    logic [PIX_W-1:0] line_above  [MAX_LINE_WIDTH];
    logic [PIX_W-1:0] line_above2 [MAX_LINE_WIDTH];
    logic [PIX_W-1:0] win         [WIN_N];
    int               col_pos;
    int               row_pos;
    t_edge_result     edge_fifo   [$];

    // Integer root of Gh^2 + Gv^2 over the current window, scaled down by 8
    function automatic logic [MAG_W-1:0] window_magnitude();
        int gh;
        int gv;
        int sum;
        int root;
        int trial;
        gh = int'(win[0]) + 2 * int'(win[1]) + int'(win[2])
           - int'(win[6]) - 2 * int'(win[7]) - int'(win[8]);
        gv = int'(win[0]) - int'(win[2]) + 2 * int'(win[3])
           - 2 * int'(win[5]) + int'(win[6]) - int'(win[8]);
        sum = gh * gh + gv * gv;
        root = 0;
        for (int b = 11; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sum) begin
                root = trial;
            end
        end
        root = root >> 3;
        return root[MAG_W-1:0];
    endfunction

    // Slide the window over one pixel and queue the result it yields, if any
    task automatic take_pixel(input logic [PIX_W-1:0] pix);
        int           w_eff;
        int           h_eff;
        t_edge_result res;
        w_eff = int'(regs.line_width);
        if (w_eff < 3) w_eff = 3;
        if (w_eff > MAX_LINE_WIDTH) w_eff = MAX_LINE_WIDTH;
        h_eff = int'(regs.frame_height);
        if (h_eff < 3) h_eff = 3;

        for (int r = 0; r < 3; r++) begin
            win[3 * r]     = win[3 * r + 1];
            win[3 * r + 1] = win[3 * r + 2];
        end
        win[2] = line_above2[col_pos];
        win[5] = line_above[col_pos];
        win[8] = pix;
        line_above2[col_pos] = line_above[col_pos];
        line_above[col_pos]  = pix;

        if (col_pos >= 2 && row_pos >= 2) begin
            res.magnitude  = window_magnitude();
            res.edge_pixel = (res.magnitude >= regs.edge_threshold) ? EDGE_ON : EDGE_OFF;
            res.frame_last = (col_pos == w_eff - 1 && row_pos == h_eff - 1);
            edge_fifo.push_back(res);
        end

        // Close the line (and plane) at or past the bound in use
        if (col_pos + 1 >= w_eff) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h_eff) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        o_fail_count++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // Compare one output beat against the oldest prediction
    task automatic check_beat();
        t_edge_result want;
        if (edge_fifo.size() == 0) begin
            o_fail_count++;
            $display("%0t: beat expected none, got edge_pixel %0d magnitude %0d last %0d",
                     $time, i_edge_pixel, i_magnitude, i_frame_last);
        end else begin
            want = edge_fifo.pop_front();
            if (i_edge_pixel !== want.edge_pixel)
                note_mismatch("edge_pixel", want.edge_pixel, i_edge_pixel);
            if (i_magnitude !== want.magnitude)
                note_mismatch("magnitude", want.magnitude, i_magnitude);
            if (i_frame_last !== want.frame_last)
                note_mismatch("frame_last", want.frame_last, i_frame_last);
        end
    endtask

    // Track config, predict on accepted pixels, check accepted beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.line_width     = RST_LINE_WIDTH;
            regs.frame_height   = RST_FRAME_HEIGHT;
            regs.edge_threshold = RST_EDGE_THRESHOLD;
            for (int k = 0; k < WIN_N; k++) begin
                win[k] = '0;
            end
            col_pos = 0;
            row_pos = 0;
            edge_fifo.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LINE_WIDTH:     regs.line_width     = i_cfg_data;
                    CFG_FRAME_HEIGHT:   regs.frame_height   = i_cfg_data;
                    CFG_EDGE_THRESHOLD: regs.edge_threshold = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                take_pixel(i_pixel);
            end
            if (i_out_valid && !i_out_stall) begin
                check_beat();
            end
        end
        o_pending = edge_fifo.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import sobel_pkg::*;

    localparam int         LINE_MAX     = 2048;
    localparam logic [1:0] CFG_NONE     = 2'd3;   // unmapped index, must be ignored
    localparam int         DRAIN_CYCLES = 64;
    localparam int         LONG_HOLD    = 300;
    localparam int         RANDOM_ITEMS = 800;

    typedef enum int {FILL_NOISE, FILL_BINARY, FILL_RAMP} t_fill;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [PIX_W-1:0] pixel;
    logic             out_valid;
    logic             out_stall;
    logic [PIX_W-1:0] edge_pixel;
    logic [MAG_W-1:0] magnitude;
    logic             frame_last;

    int fail_count;
    int pending;
    int pix_sent;
    int col_at;
    int row_at;
    int width_eff;
    int height_eff;
    bit calm;
    int hold_requests;
    int holds_done;

    sobel_edge_threshold #(.MAX_LINE_WIDTH(LINE_MAX)) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_pixel      (pixel),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_edge_pixel (edge_pixel),
        .o_magnitude  (magnitude),
        .o_frame_last (frame_last)
    );

    sobel_edge_checker #(.MAX_LINE_WIDTH(LINE_MAX)) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_pixel      (pixel),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_edge_pixel (edge_pixel),
        .i_magnitude  (magnitude),
        .i_frame_last (frame_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop if the run hangs
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // One register write, then a quiet gap with the write enable low
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        int v;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        v = int'(data);
        case (idx)
            CFG_LINE_WIDTH:   width_eff  = (v < 3) ? 3 : (v > LINE_MAX) ? LINE_MAX : v;
            CFG_FRAME_HEIGHT: height_eff = (v < 3) ? 3 : v;
            default: ;
        endcase
    endtask

    function automatic logic [PIX_W-1:0] fill_value(input t_fill how);
        int t;
        case (how)
            FILL_BINARY: t = ($urandom_range(0, 1) != 0) ? 255 : 0;
            FILL_RAMP:   t = col_at * 13 + row_at * 7 + $urandom_range(0, 5);
            default:     t = $urandom_range(0, 255);
        endcase
        return t[PIX_W-1:0];
    endfunction

    // Offer one pixel after a random gap; hold it until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            pixel    <= PIX_W'($urandom_range(0, 255));
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        pix_sent++;
        // keep our own raster position to know where planes end
        if (col_at + 1 >= width_eff) begin
            col_at = 0;
            row_at = (row_at + 1 >= height_eff) ? 0 : row_at + 1;
        end else begin
            col_at++;
        end
    endtask

    // Send pixels until the raster position wraps back to the plane start
    task automatic send_plane(input t_fill how);
        do send_pixel(fill_value(how)); while (col_at != 0 || row_at != 0);
    endtask

    // Drop valid, wait out every expected beat, then let the pipe empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Receiver: random stall before each beat, plus long holds on request
    initial begin : rx_side
        int gap;
        out_stall  = 1'b0;
        holds_done = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (holds_done != hold_requests) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
            end
            gap = calm ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid || out_stall);
            @(negedge clk);
        end
    end

    initial begin : stim
        int    start;
        int    phase;
        int    cut;
        int    thr;
        t_fill how;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        pixel         = '0;
        calm          = 1'b0;
        hold_requests = 0;
        pix_sent      = 0;
        col_at        = 0;
        row_at        = 0;
        width_eff     = int'(RST_LINE_WIDTH);
        height_eff    = int'(RST_FRAME_HEIGHT);
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Smallest plane from saturated zero bounds; zero threshold flags everything
        write_reg(CFG_LINE_WIDTH, '0);
        write_reg(CFG_FRAME_HEIGHT, '0);
        write_reg(CFG_EDGE_THRESHOLD, '0);
        write_reg(CFG_NONE, '1);
        for (int i = 0; i < 9; i++) begin
            send_pixel((i < 3) ? 8'hFF : 8'h00);
        end
        wait_idle();

        // Diagonal step at full contrast; top threshold flags nothing
        write_reg(CFG_LINE_WIDTH, 12'd5);
        write_reg(CFG_FRAME_HEIGHT, 12'd3);
        write_reg(CFG_EDGE_THRESHOLD, 12'hFFF);
        for (int i = 0; i < 15; i++) begin
            send_pixel((i % 5 <= i / 5) ? 8'hFF : 8'h00);
        end
        wait_idle();

        // Random planes, a few cut short and re-bounded midway
        phase = 0;
        start = pix_sent;
        while (pix_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(CFG_LINE_WIDTH, CFG_W'($urandom_range(0, 2)));
                    1:       write_reg(CFG_LINE_WIDTH, CFG_W'($urandom_range(13, 40)));
                    default: write_reg(CFG_LINE_WIDTH, CFG_W'($urandom_range(3, 12)));
                endcase
            end
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 9) == 0)
                    write_reg(CFG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 2)));
                else
                    write_reg(CFG_FRAME_HEIGHT, CFG_W'($urandom_range(3, 8)));
            end
            case ($urandom_range(0, 7))
                0:       thr = 0;
                1:       thr = 12'hFFF;
                default: thr = ($urandom_range(0, 15) << 8) | $urandom_range(0, 180);
            endcase
            write_reg(CFG_EDGE_THRESHOLD, CFG_W'(thr));

            calm = ($urandom_range(0, 4) == 0);
            how  = t_fill'($urandom_range(0, 2));

            // Back up the output on a plane big enough to fill the block
            if (phase == 2 || phase == 11) begin
                write_reg(CFG_LINE_WIDTH, 12'd12);
                write_reg(CFG_FRAME_HEIGHT, 12'd8);
                calm = 1'b0;
                hold_requests++;
            end

            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, width_eff * height_eff - 1);
                repeat (cut) send_pixel(fill_value(how));
                wait_idle();
                // narrow only: a wider line would reach columns not yet stored
                write_reg(CFG_LINE_WIDTH, CFG_W'($urandom_range(3, width_eff)));
                if ($urandom_range(0, 1) != 0) begin
                    write_reg(CFG_FRAME_HEIGHT, CFG_W'($urandom_range(1, 10)));
                end
            end
            send_plane(how);
            wait_idle();
            phase++;
        end

        calm = 1'b0;
        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
